// ===== rtl/core/hid_report_usage_matcher_assert.svh =====
// Assertion macros shared by the checker of the HID report usage matcher.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef HID_REPORT_USAGE_MATCHER_ASSERT_SVH
`define HID_REPORT_USAGE_MATCHER_ASSERT_SVH

// Checked at every rising edge of clk while reset is released.
`define HRUM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hid report usage matcher: assertion failed");

// Checked at every rising edge of clk, reset included.
`define HRUM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hid report usage matcher: assertion failed");

`endif

// ===== rtl/core/hrum_pkg.sv =====
// Types and constants of the HID report usage matcher.
// Depends on nothing; used by the parser and the top level.
`default_nettype none

package hrum_pkg;

  typedef enum logic [1:0] {
    PH_HEADER    = 2'd0,
    PH_LONG_LEN  = 2'd1,
    PH_LONG_SKIP = 2'd2,
    PH_VALUE     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_PAGE  = 2'd1,
    KIND_USAGE = 2'd2
  } kind_t;

  typedef logic [1:0] verdict_t;

  localparam verdict_t VERD_NONE  = 2'd0;
  localparam verdict_t VERD_MATCH = 2'd1;
  localparam verdict_t VERD_BAD   = 2'd2;

  localparam logic [7:0]  LONG_ITEM_HDR = 8'hFE;
  localparam logic [3:0]  TAG_USAGE     = 4'd0;
  localparam logic [1:0]  TYPE_GLOBAL   = 2'd1;
  localparam logic [1:0]  TYPE_LOCAL    = 2'd2;
  localparam logic [1:0]  SIZE_CODE_4   = 2'd3;
  localparam logic [31:0] TARGET_RESET  = 32'hF1D0_0001;

  // One descriptor byte as it travels from the input register to the parser.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/hid_report_usage_matcher.sv =====
// Top level of the HID report usage matcher: input register, parser, result register.
// Depends on hrum_pkg and hrum_parser.
//
// Use of the block:
//   The input channel (in_valid, in_stall, in_data_byte, in_last_byte) takes one
//   descriptor byte per item; in_last_byte marks the final byte of a descriptor.
//   The result channel (out_valid, out_stall, out_verdict) gives one item for each
//   descriptor, on its final byte: 0 no match, 1 target usage found, 2 malformed.
//   Bytes that are not final give no result item.
//   The configuration channel (cfg_valid, cfg_ready, cfg_target_usage) writes the
//   32-bit usage (page in the upper half, id in the lower half) to look for. It
//   is to be written by the user only while the block is idle; the block does not
//   enforce this: cfg_ready is low only while a byte sits in the input register.
//   A final byte taken into the input register passes the parser, and its verdict
//   enters the result register that drives out_verdict, unless a stalled result
//   holds it back. Throughput: one byte every cycle while in_stall is low, set by
//   the single pass of the parser between the input register and the result register.
//   A result waiting under out_stall does not block bytes that produce no
//   result; only a further final byte waits in the input register, and then
//   in_stall rises. Out_stall thus reaches in_stall through one gate.
//   Reset (rst_n low at a clock edge) empties both registers, returns the
//   parser to the start of a descriptor and loads the target usage 0xF1D00001.
`default_nettype none

module hid_report_usage_matcher (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_data_byte,
  input  wire        in_last_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] out_verdict,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [31:0] cfg_target_usage
);

  // Input register: holds one byte until the parser has taken it.
  hrum_pkg::byte_item_t s1_item_r;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_adv;
  logic                 in_take;

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  hrum_pkg::verdict_t   out_verdict_r;
  hrum_pkg::verdict_t   parse_verdict;

  logic [31:0]          target_r;

  // A byte moves on unless it carries a result and the result register is full
  // and stalled.
  assign s1_adv   = s1_valid_r && (!s1_item_r.last_byte || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = !s1_valid_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_item_r.last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      target_r    <= hrum_pkg::TARGET_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        target_r <= cfg_target_usage;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.data_byte <= in_data_byte;
      s1_item_r.last_byte <= in_last_byte;
    end
    if (s1_adv && s1_item_r.last_byte) begin
      out_verdict_r <= parse_verdict;
    end
  end

  hrum_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_adv),
    .item         (s1_item_r),
    .target_usage (target_r),
    .verdict      (parse_verdict)
  );

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

`default_nettype wire

// ===== rtl/core/hrum_parser.sv =====
// Item parser of the HID report usage matcher: parse state and its update.
// Depends on hrum_pkg.
`default_nettype none

module hrum_parser (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 step,
  input  hrum_pkg::byte_item_t item,
  input  wire [31:0]          target_usage,
  output hrum_pkg::verdict_t  verdict
);

  hrum_pkg::phase_t   phase_r, phase_nxt;
  hrum_pkg::kind_t    kind_r, kind_nxt;
  logic [8:0]         bytes_left_r, bytes_left_nxt;
  logic [31:0]        value_acc_r, value_acc_nxt;
  logic [1:0]         byte_idx_r, byte_idx_nxt;
  logic [2:0]         item_size_r, item_size_nxt;
  logic [31:0]        usage_r, usage_nxt;
  logic               decided_r, decided_nxt;
  hrum_pkg::verdict_t latched_r, latched_nxt;

  logic        fin_en;
  logic [31:0] fin_val;
  logic [31:0] usage_new;
  logic [8:0]  bytes_dec;
  logic [7:0]  b;

  assign b         = item.data_byte;
  assign bytes_dec = bytes_left_r - 9'd1;

  always_comb begin
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    bytes_left_nxt = bytes_left_r;
    value_acc_nxt  = value_acc_r;
    byte_idx_nxt   = byte_idx_r;
    item_size_nxt  = item_size_r;
    usage_nxt      = usage_r;
    decided_nxt    = decided_r;
    latched_nxt    = latched_r;
    fin_en         = 1'b0;
    fin_val        = value_acc_r;
    usage_new      = usage_r;
    verdict        = hrum_pkg::VERD_NONE;

    if (!decided_r) begin
      unique case (phase_r)
        hrum_pkg::PH_LONG_LEN: begin
          bytes_left_nxt = {1'b0, b} + 9'd1;
          phase_nxt      = hrum_pkg::PH_LONG_SKIP;
        end
        hrum_pkg::PH_LONG_SKIP: begin
          bytes_left_nxt = bytes_dec;
          if (bytes_dec == 9'd0) begin
            phase_nxt = hrum_pkg::PH_HEADER;
          end
        end
        hrum_pkg::PH_VALUE: begin
          // Value bytes arrive little-endian into a cleared accumulator.
          value_acc_nxt[{byte_idx_r, 3'b000} +: 8] =
            value_acc_r[{byte_idx_r, 3'b000} +: 8] | b;
          byte_idx_nxt   = byte_idx_r + 2'd1;
          bytes_left_nxt = bytes_dec;
          if (bytes_dec == 9'd0) begin
            phase_nxt = hrum_pkg::PH_HEADER;
            fin_en    = 1'b1;
            fin_val   = value_acc_nxt;
          end
        end
        default: begin
          phase_nxt = hrum_pkg::PH_HEADER;
          if (b == hrum_pkg::LONG_ITEM_HDR) begin
            if (item.last_byte) begin
              decided_nxt = 1'b1;
              latched_nxt = hrum_pkg::VERD_BAD;
            end else begin
              phase_nxt = hrum_pkg::PH_LONG_LEN;
            end
          end else begin
            item_size_nxt = (b[1:0] == hrum_pkg::SIZE_CODE_4) ? 3'd4 : {1'b0, b[1:0]};
            if (b[7:4] == hrum_pkg::TAG_USAGE && b[3:2] == hrum_pkg::TYPE_GLOBAL) begin
              kind_nxt = hrum_pkg::KIND_PAGE;
            end else if (b[7:4] == hrum_pkg::TAG_USAGE && b[3:2] == hrum_pkg::TYPE_LOCAL) begin
              kind_nxt = hrum_pkg::KIND_USAGE;
            end else begin
              kind_nxt = hrum_pkg::KIND_OTHER;
            end
            if (item_size_nxt == 3'd0) begin
              fin_en  = 1'b1;
              fin_val = 32'd0;
            end else begin
              phase_nxt      = hrum_pkg::PH_VALUE;
              bytes_left_nxt = {6'd0, item_size_nxt};
              byte_idx_nxt   = 2'd0;
              value_acc_nxt  = 32'd0;
            end
          end
        end
      endcase
    end

    // Completion of a short item: page and usage updates, oversized page check, match check.
    if (fin_en) begin
      if (kind_nxt == hrum_pkg::KIND_PAGE) begin
        if (item_size_nxt > 3'd2) begin
          decided_nxt = 1'b1;
          latched_nxt = hrum_pkg::VERD_BAD;
        end else begin
          usage_nxt = {fin_val[15:0], 16'h0000};
        end
      end else if (kind_nxt == hrum_pkg::KIND_USAGE) begin
        usage_new = (item_size_nxt == 3'd4) ? fin_val : {usage_r[31:16], fin_val[15:0]};
        usage_nxt = usage_new;
        if (usage_new == target_usage) begin
          decided_nxt = 1'b1;
          latched_nxt = hrum_pkg::VERD_MATCH;
        end
      end
    end

    if (decided_nxt) begin
      verdict = latched_nxt;
    end else if (phase_nxt == hrum_pkg::PH_VALUE) begin
      verdict = hrum_pkg::VERD_BAD;
    end

    // The final byte closes the descriptor; the next byte starts afresh.
    if (item.last_byte) begin
      phase_nxt      = hrum_pkg::PH_HEADER;
      kind_nxt       = hrum_pkg::KIND_OTHER;
      bytes_left_nxt = 9'd0;
      value_acc_nxt  = 32'd0;
      byte_idx_nxt   = 2'd0;
      item_size_nxt  = 3'd0;
      usage_nxt      = 32'd0;
      decided_nxt    = 1'b0;
      latched_nxt    = hrum_pkg::VERD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= hrum_pkg::PH_HEADER;
      kind_r       <= hrum_pkg::KIND_OTHER;
      bytes_left_r <= 9'd0;
      value_acc_r  <= 32'd0;
      byte_idx_r   <= 2'd0;
      item_size_r  <= 3'd0;
      usage_r      <= 32'd0;
      decided_r    <= 1'b0;
      latched_r    <= hrum_pkg::VERD_NONE;
    end else if (step) begin
      phase_r      <= phase_nxt;
      kind_r       <= kind_nxt;
      bytes_left_r <= bytes_left_nxt;
      value_acc_r  <= value_acc_nxt;
      byte_idx_r   <= byte_idx_nxt;
      item_size_r  <= item_size_nxt;
      usage_r      <= usage_nxt;
      decided_r    <= decided_nxt;
      latched_r    <= latched_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hrum_checker.sv =====
// Port-level checker of the HID report usage matcher, bound to the top level.
// Depends on hid_report_usage_matcher_assert.svh.
`default_nettype none

`include "hid_report_usage_matcher_assert.svh"

module hrum_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_stall,
  input wire       in_last_byte,
  input wire       out_valid,
  input wire       out_stall,
  input wire [1:0] out_verdict,
  input wire       cfg_ready
);

  // A waiting result holds its verdict.
  `HRUM_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_verdict))
  // With the result register empty, every byte moves on.
  `HRUM_ASSERT(a_no_stall_when_empty, clk, rst_n, !out_valid |-> !in_stall)
  // A final byte just taken occupies the input register, so configuration waits.
  `HRUM_ASSERT(a_cfg_blocked, clk, rst_n, in_valid && !in_stall && in_last_byte |=> !cfg_ready)
  // Reset leaves no result behind.
  `HRUM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind hid_report_usage_matcher hrum_checker u_hrum_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_last_byte (in_last_byte),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_verdict  (out_verdict),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire
